// ----- design/necir_pkg.sv -----
package necir_pkg;

    localparam int TIME_W      = 32;
    localparam int STEP_W      = 6;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 20;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TIME_W-1:0]     SPARE_MARGIN_US = 32'd5000;
    localparam logic [CFG_DATA_W-1:0] AUTO_END_RESET  = 20'd125000;
    localparam logic                  IDLE_RESET      = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IDLE_LEVEL = 8'd0,
        REG_AUTO_END   = 8'd1
    } reg_idx_t;

    typedef enum logic [2:0] {
        CLS_INVALID,
        CLS_ZERO,
        CLS_ONE,
        CLS_START,
        CLS_REPEAT,
        CLS_END
    } cls_t;

    typedef enum logic {
        KIND_NEW = 1'b0,
        KIND_END = 1'b1
    } kind_t;

    // One event handed from the front to the back
    typedef struct packed {
        logic              tick;
        cls_t              cls;
        logic [TIME_W-1:0] now;
    } evt_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

    // a is after b when (a - b) mod 2^32 lies in 1 .. 2^31-1
    function automatic logic is_after(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        begin
            d = a - b;
            is_after = (d != '0) && !d[TIME_W-1];
        end
    endfunction

endpackage

// ----- design/necir_front.sv -----
module necir_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             idle_level,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             in_tick,
    input  logic                             in_rising,
    input  logic [necir_pkg::TIME_W-1:0]     in_time,
    input  necir_pkg::q_status_t             q_stat,
    output logic                             push,
    output necir_pkg::evt_t                  push_evt
);
    import necir_pkg::*;

    logic              pulse_open_reg,  pulse_open_next;
    logic [TIME_W-1:0] pulse_begin_reg, pulse_begin_next;
    logic              prior_valid_reg, prior_valid_next;
    logic [TIME_W-1:0] prior_end_reg,   prior_end_next;
    logic [TIME_W-1:0] prior_len_reg,   prior_len_next;

    logic              fire;
    logic [TIME_W-1:0] space;

    function automatic cls_t classify(input logic [TIME_W-1:0] mark,
                                      input logic [TIME_W-1:0] gap);
        cls_t c;
        begin
            c = CLS_INVALID;
            if (mark > 32'd500 && mark < 32'd650) begin
                if (gap > 32'd500 && gap < 32'd650)
                    c = CLS_ZERO;
                else if (gap > 32'd1600 && gap < 32'd1750)
                    c = CLS_ONE;
                else if (gap >= 32'd1750)
                    c = CLS_END;
            end
            else if (mark > 32'd8000 && mark < 32'd10000) begin
                if (gap > 32'd2000 && gap < 32'd2500)
                    c = CLS_REPEAT;
                else if (gap > 32'd4000 && gap < 32'd5000)
                    c = CLS_START;
            end
            classify = c;
        end
    endfunction

    assign in_ready = !q_stat.full;
    assign fire     = in_valid && in_ready;

    // Space between the prior pulse's end and the start of the pulse now closing
    assign space = pulse_begin_reg - prior_end_reg;

    always_comb
    begin
        pulse_open_next  = pulse_open_reg;
        pulse_begin_next = pulse_begin_reg;
        prior_valid_next = prior_valid_reg;
        prior_end_next   = prior_end_reg;
        prior_len_next   = prior_len_reg;
        push             = 1'b0;
        push_evt.tick    = in_tick;
        push_evt.cls     = classify(prior_len_reg, space);
        push_evt.now     = in_time;
        if (fire) begin
            if (in_tick) begin
                push = 1'b1;
            end
            else if (!pulse_open_reg) begin
                if (in_rising != idle_level) begin
                    pulse_open_next  = 1'b1;
                    pulse_begin_next = in_time;
                end
            end
            else begin
                // close the pulse; classify the one before it
                pulse_open_next  = 1'b0;
                push             = prior_valid_reg;
                prior_valid_next = 1'b1;
                prior_end_next   = in_time;
                prior_len_next   = in_time - pulse_begin_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pulse_open_reg  <= 1'b0;
            pulse_begin_reg <= '0;
            prior_valid_reg <= 1'b0;
            prior_end_reg   <= '0;
            prior_len_reg   <= '0;
        end
        else begin
            pulse_open_reg  <= pulse_open_next;
            pulse_begin_reg <= pulse_begin_next;
            prior_valid_reg <= prior_valid_next;
            prior_end_reg   <= prior_end_next;
            prior_len_reg   <= prior_len_next;
        end
    end

    a_push_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (in_valid && !q_stat.full))
        else $error("front pushed without an accepted beat");

endmodule

// ----- design/necir_queue.sv -----
module necir_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  necir_pkg::evt_t      push_evt,
    input  logic                 pop,
    output necir_pkg::q_status_t stat,
    output necir_pkg::evt_t      head_evt
);
    import necir_pkg::*;

    evt_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg,  count_next;

    assign stat.not_empty = (count_reg != '0);
    assign stat.full      = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head_evt       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_evt;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= QUEUE_CW'(QUEUE_DEPTH)) && !(push && stat.full) && !(pop && !stat.not_empty))
        else $error("event queue overflow or underflow");

endmodule

// ----- design/necir_back.sv -----
module necir_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [necir_pkg::CFG_DATA_W-1:0]     auto_end,
    input  logic [necir_pkg::TIME_W-1:0]         spare_delay,
    input  necir_pkg::q_status_t                 q_stat,
    input  necir_pkg::evt_t                      q_evt,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 out_kind,
    output logic [7:0]                           out_address,
    output logic [7:0]                           out_code
);
    import necir_pkg::*;

    logic [31:0]       frame_bits_reg,   frame_bits_next;
    logic [STEP_W-1:0] bit_step_reg,     bit_step_next;
    logic              expect_end_reg,   expect_end_next;
    logic              cancelled_reg,    cancelled_next;
    logic [TIME_W-1:0] grace_end_reg,    grace_end_next;
    logic              armed_reg,        armed_next;
    logic [TIME_W-1:0] deadline_reg,     deadline_next;
    logic              out_valid_reg,    out_valid_next;
    logic              out_kind_reg,     out_kind_next;
    logic [7:0]        out_address_reg,  out_address_next;
    logic [7:0]        out_code_reg,     out_code_next;

    logic              end_try;
    logic              can_end;
    logic              arm;
    logic              start_frame;
    logic              emit_new;
    logic [31:0]       bits_set;
    logic [STEP_W-1:0] step_inc;

    assign pop         = q_stat.not_empty && (!out_valid_reg || out_ready);
    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_address = out_address_reg;
    assign out_code    = out_code_reg;

    assign can_end  = !cancelled_reg && is_after(q_evt.now, grace_end_reg);
    // wrap from 63 back to 62 so the step parity keeps alternating
    assign step_inc = (bit_step_reg == '1) ? STEP_W'(62) : bit_step_reg + 1'b1;
    assign bits_set = frame_bits_reg | (32'd1 << bit_step_reg[4:0]);

    always_comb
    begin
        frame_bits_next   = frame_bits_reg;
        bit_step_next     = bit_step_reg;
        expect_end_next   = expect_end_reg;
        cancelled_next    = cancelled_reg;
        grace_end_next    = grace_end_reg;
        armed_next        = armed_reg;
        deadline_next     = deadline_reg;
        out_valid_next    = out_valid_reg;
        out_kind_next     = out_kind_reg;
        out_address_next  = out_address_reg;
        out_code_next     = out_code_reg;
        end_try           = 1'b0;
        arm               = 1'b0;
        start_frame       = 1'b0;
        emit_new          = 1'b0;

        if (out_ready)
            out_valid_next = 1'b0;

        if (pop) begin
            out_valid_next = 1'b0;
            if (q_evt.tick) begin
                if (armed_reg && !is_after(deadline_reg, q_evt.now)) begin
                    armed_next = 1'b0;
                    end_try    = 1'b1;
                end
            end
            else if (cancelled_reg) begin
                start_frame = (q_evt.cls == CLS_START);
            end
            else begin
                case (q_evt.cls)
                    CLS_START:
                    begin
                        end_try     = 1'b1;
                        start_frame = 1'b1;
                    end
                    CLS_END:
                    begin
                        if (!expect_end_reg)
                            end_try = 1'b1;
                        else begin
                            expect_end_next = 1'b0;
                            bit_step_next   = step_inc;
                        end
                    end
                    CLS_ONE, CLS_ZERO:
                    begin
                        if (bit_step_reg > STEP_W'(31))
                            end_try = 1'b1;
                        else begin
                            if (q_evt.cls == CLS_ONE)
                                frame_bits_next = bits_set;
                            bit_step_next = step_inc;
                            if (bit_step_reg == STEP_W'(31)) begin
                                expect_end_next = 1'b1;
                                emit_new = (frame_bits_next[7:0] == ~frame_bits_next[15:8])
                                        && (frame_bits_next[23:16] == ~frame_bits_next[31:24]);
                            end
                        end
                    end
                    CLS_REPEAT:
                    begin
                        if (bit_step_reg > STEP_W'(32) && bit_step_reg[0]) begin
                            expect_end_next = 1'b1;
                            arm             = 1'b1;
                            bit_step_next   = step_inc;
                        end
                        else
                            end_try = 1'b1;
                    end
                    default:
                        end_try = 1'b1;
                endcase
            end

            if (emit_new) begin
                out_valid_next   = 1'b1;
                out_kind_next    = KIND_NEW;
                out_address_next = frame_bits_next[7:0];
                out_code_next    = frame_bits_next[23:16];
            end
            if (end_try && can_end) begin
                cancelled_next   = 1'b1;
                armed_next       = 1'b0;
                out_valid_next   = 1'b1;
                out_kind_next    = KIND_END;
                out_address_next = '0;
                out_code_next    = '0;
            end
            if (start_frame) begin
                frame_bits_next = '0;
                bit_step_next   = '0;
                expect_end_next = 1'b0;
                cancelled_next  = 1'b0;
            end
            if (arm || start_frame) begin
                grace_end_next = q_evt.now + spare_delay;
                deadline_next  = q_evt.now + TIME_W'(auto_end);
                armed_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_bits_reg   <= '0;
            bit_step_reg     <= '0;
            expect_end_reg   <= 1'b0;
            cancelled_reg    <= 1'b1;
            grace_end_reg    <= '0;
            armed_reg        <= 1'b0;
            deadline_reg     <= '0;
            out_valid_reg    <= 1'b0;
            out_kind_reg     <= KIND_NEW;
            out_address_reg  <= '0;
            out_code_reg     <= '0;
        end
        else begin
            frame_bits_reg   <= frame_bits_next;
            bit_step_reg     <= bit_step_next;
            expect_end_reg   <= expect_end_next;
            cancelled_reg    <= cancelled_next;
            grace_end_reg    <= grace_end_next;
            armed_reg        <= armed_next;
            deadline_reg     <= deadline_next;
            out_valid_reg    <= out_valid_next;
            out_kind_reg     <= out_kind_next;
            out_address_reg  <= out_address_next;
            out_code_reg     <= out_code_next;
        end
    end

    a_end_cancels: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && end_try && can_end && !start_frame) |=> cancelled_reg)
        else $error("end result left the frame active");

    a_expect_end_step: assert property (@(posedge clk) disable iff (!rst_n)
        expect_end_reg |-> (bit_step_reg >= STEP_W'(32)))
        else $error("end mark expected before the frame was complete");

    a_new_only_active: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && emit_new) |-> !cancelled_reg)
        else $error("new command reported on a cancelled frame");

endmodule

// ----- design/nec_ir_frame_decoder.sv -----
// NEC IR frame decoder: edge/tick events in, command and command-end beats out.
// m_tvalid is registered: the event queue stores the causing beat, and the frame unit
// pops it into the output register when nothing is queued ahead and it is free.
// Throughput: one event per cycle; s_tready drops only while the event queue is full,
// and the frame unit drains one queued event a cycle while its output register is free.
// Reset (rst_n low, asynchronous): idle_level 1, auto_end_us 125000, no frame active.
module nec_ir_frame_decoder (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [39:0]                           s_tdata,   // rising, time_us, zero pad
    input  logic                                  s_tuser,   // tick
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [15:0]                           m_tdata,   // address, code
    output logic                                  m_tuser,   // kind
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [necir_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [necir_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import necir_pkg::*;

    logic                  idle_level_reg;
    logic [CFG_DATA_W-1:0] auto_end_reg;
    logic [TIME_W-1:0]     spare_delay_reg;

    logic      push;
    evt_t      push_evt;
    logic      pop;
    q_status_t q_stat;
    evt_t      head_evt;
    logic [7:0] address;
    logic [7:0] code;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idle_level_reg  <= IDLE_RESET;
            auto_end_reg    <= AUTO_END_RESET;
            spare_delay_reg <= TIME_W'(AUTO_END_RESET) - SPARE_MARGIN_US;
        end
        else if (cfg_valid) begin
            case (cfg_index)
                REG_IDLE_LEVEL:
                    idle_level_reg <= cfg_data[0];
                REG_AUTO_END:
                begin
                    auto_end_reg    <= cfg_data;
                    spare_delay_reg <= TIME_W'(cfg_data) - SPARE_MARGIN_US;
                end
                default:
                    idle_level_reg <= idle_level_reg;
            endcase
        end
    end

    necir_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .idle_level (idle_level_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_tick    (s_tuser),
        .in_rising  (s_tdata[0]),
        .in_time    (s_tdata[32:1]),
        .q_stat     (q_stat),
        .push       (push),
        .push_evt   (push_evt)
    );

    necir_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_evt (push_evt),
        .pop      (pop),
        .stat     (q_stat),
        .head_evt (head_evt)
    );

    necir_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .auto_end    (auto_end_reg),
        .spare_delay (spare_delay_reg),
        .q_stat      (q_stat),
        .q_evt       (head_evt),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (m_tuser),
        .out_address (address),
        .out_code    (code)
    );

    assign m_tdata = {code, address};

endmodule
